/* rtl/oms_pkg.sv */
package oms_pkg;

    localparam int REG_ADDR_W  = 5;
    localparam int REG_DATA_W  = 32;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_LINEAR_SCALE  = 3'd0;
    localparam logic [2:0] REG_TURN_SCALE    = 3'd1;
    localparam logic [2:0] REG_DETOUR_DRIVE  = 3'd2;
    localparam logic [2:0] REG_DETOUR_TURN   = 3'd3;
    localparam logic [2:0] REG_BACKUP_LEN    = 3'd4;
    localparam logic [2:0] REG_SIDESTEP_LEN  = 3'd5;
    localparam logic [2:0] REG_PASS_LEN      = 3'd6;
    localparam logic [2:0] REG_DETOUR_ANGLE  = 3'd7;

    localparam logic [15:0] RST_LINEAR_SCALE = 16'd4096;
    localparam logic [15:0] RST_TURN_SCALE   = 16'd4096;
    localparam logic [8:0]  RST_DETOUR_DRIVE = 9'd75;
    localparam logic [8:0]  RST_DETOUR_TURN  = 9'd100;
    localparam logic [15:0] RST_BACKUP_LEN   = 16'd150;
    localparam logic [15:0] RST_SIDESTEP_LEN = 16'd250;
    localparam logic [15:0] RST_PASS_LEN     = 16'd150;
    localparam logic [8:0]  RST_DETOUR_ANGLE = 9'd90;

    localparam logic       REQ_START  = 1'b0;
    localparam logic       REQ_SENSOR = 1'b1;

    localparam logic [2:0] KIND_AVOID = 3'd0;
    localparam logic [2:0] KIND_FWD   = 3'd1;
    localparam logic [2:0] KIND_BACK  = 3'd2;
    localparam logic [2:0] KIND_CCW   = 3'd3;
    localparam logic [2:0] KIND_CW    = 3'd4;

    localparam logic [8:0] MAX_SPEED  = 9'd500;

    typedef enum logic [2:0] {
        PH_MAIN      = 3'd0,
        PH_BACKUP    = 3'd1,
        PH_TURN_OUT  = 3'd2,
        PH_SIDESTEP  = 3'd3,
        PH_TURN_BACK = 3'd4,
        PH_PASS      = 3'd5
    } t_phase;

    typedef struct packed {
        logic [15:0] linear_scale;
        logic [15:0] turn_scale;
        logic [8:0]  detour_drive_speed;
        logic [8:0]  detour_turn_speed;
        logic [15:0] backup_length;
        logic [15:0] sidestep_length;
        logic [15:0] pass_length;
        logic [8:0]  detour_angle;
    } t_cfg;

endpackage

/* rtl/oms_regs.sv */
module oms_regs
    import oms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [REG_DATA_W-1:0] pwdata,
    output logic [REG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[REG_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.linear_scale       <= RST_LINEAR_SCALE;
            r_cfg.turn_scale         <= RST_TURN_SCALE;
            r_cfg.detour_drive_speed <= RST_DETOUR_DRIVE;
            r_cfg.detour_turn_speed  <= RST_DETOUR_TURN;
            r_cfg.backup_length      <= RST_BACKUP_LEN;
            r_cfg.sidestep_length    <= RST_SIDESTEP_LEN;
            r_cfg.pass_length        <= RST_PASS_LEN;
            r_cfg.detour_angle       <= RST_DETOUR_ANGLE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LINEAR_SCALE: r_cfg.linear_scale       <= pwdata[15:0];
                REG_TURN_SCALE:   r_cfg.turn_scale         <= pwdata[15:0];
                REG_DETOUR_DRIVE: r_cfg.detour_drive_speed <= pwdata[8:0];
                REG_DETOUR_TURN:  r_cfg.detour_turn_speed  <= pwdata[8:0];
                REG_BACKUP_LEN:   r_cfg.backup_length      <= pwdata[15:0];
                REG_SIDESTEP_LEN: r_cfg.sidestep_length    <= pwdata[15:0];
                REG_PASS_LEN:     r_cfg.pass_length        <= pwdata[15:0];
                REG_DETOUR_ANGLE: r_cfg.detour_angle       <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LINEAR_SCALE: prdata = {16'd0, r_cfg.linear_scale};
            REG_TURN_SCALE:   prdata = {16'd0, r_cfg.turn_scale};
            REG_DETOUR_DRIVE: prdata = {23'd0, r_cfg.detour_drive_speed};
            REG_DETOUR_TURN:  prdata = {23'd0, r_cfg.detour_turn_speed};
            REG_BACKUP_LEN:   prdata = {16'd0, r_cfg.backup_length};
            REG_SIDESTEP_LEN: prdata = {16'd0, r_cfg.sidestep_length};
            REG_PASS_LEN:     prdata = {16'd0, r_cfg.pass_length};
            REG_DETOUR_ANGLE: prdata = {23'd0, r_cfg.detour_angle};
            default:          prdata = '0;
        endcase
    end

endmodule

/* rtl/odometry_move_sequencer.sv */
// Channel   Handshake                     Payload
// ------------------------------------------------------------------------------
// in        i_in_valid / o_in_stall       req_type, move_kind, target_amount,
//                                         drive_speed, distance/angle delta, bumps
// out       o_out_valid / i_out_stall     right_wheel, left_wheel, busy_res,
//                                         done_res, detour_step
// config    psel/penable/pwrite/pready    eight registers at byte address 4*index
//
// One item per cycle while o_in_stall is low; its registered result shows next cycle.
// The cycle is set by a 32-bit saturating add feeding a 45-bit goal compare and by the
// shared 16x16 goal multiplier, all between the state registers and the result register.
// Reset (synchronous, active low) clears the move state and loads register defaults.
// o_in_stall is high only while a result waits and the output side stalls.
module odometry_move_sequencer
    import oms_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_req_type,
    input  logic [2:0]              i_move_kind,
    input  logic [15:0]             i_target_amount,
    input  logic [8:0]              i_drive_speed,
    input  logic signed [15:0]      i_distance_delta,
    input  logic signed [15:0]      i_angle_delta,
    input  logic                    i_bump_left,
    input  logic                    i_bump_right,

    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [9:0]       o_right_wheel,
    output logic signed [9:0]       o_left_wheel,
    output logic                    o_busy_res,
    output logic                    o_done_res,
    output logic [2:0]              o_detour_step,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [REG_ADDR_W-1:0]   paddr,
    input  logic [REG_DATA_W-1:0]   pwdata,
    output logic [REG_DATA_W-1:0]   prdata,
    output logic                    pready
);

    function automatic logic is_turn(input logic [2:0] k);
        return (k == KIND_CCW) || (k == KIND_CW);
    endfunction

    function automatic logic [8:0] sat_speed(input logic [8:0] s);
        return (s > MAX_SPEED) ? MAX_SPEED : s;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [15:0] d);
        logic signed [32:0] s;
        s = $signed({a[31], a}) + $signed({{17{d[15]}}, d});
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[31:0];
    endfunction

    // accumulator taken in the move's direction, scaled by 4096, against goal
    function automatic logic reached(input logic [2:0] k, input logic signed [31:0] acc,
                                     input logic [31:0] goal);
        logic signed [32:0] v;
        logic signed [44:0] lhs;
        logic signed [44:0] rhs;
        v = $signed({acc[31], acc});
        if ((k == KIND_BACK) || (k == KIND_CW)) begin
            v = -v;
        end
        lhs = $signed({v, 12'd0});
        rhs = $signed({13'd0, goal});
        return lhs >= rhs;
    endfunction

    function automatic logic [2:0] seg_kind(input t_phase p, input logic side);
        case (p)
            PH_BACKUP:    return KIND_BACK;
            PH_TURN_OUT:  return side ? KIND_CW : KIND_CCW;
            PH_TURN_BACK: return side ? KIND_CCW : KIND_CW;
            default:      return KIND_FWD;
        endcase
    endfunction

    t_cfg cfg;

    oms_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // move state
    t_phase             r_phase;
    logic [2:0]         r_kind;
    logic               r_running;
    logic               r_side;
    logic [8:0]         r_speed;
    logic signed [31:0] r_main_accum;
    logic [31:0]        r_main_goal;
    logic signed [31:0] r_seg_accum;
    logic [31:0]        r_seg_goal;

    t_phase             n_phase;
    logic [2:0]         n_kind;
    logic               n_running;
    logic               n_side;
    logic [8:0]         n_speed;
    logic signed [31:0] n_main_accum;
    logic [31:0]        n_main_goal;
    logic signed [31:0] n_seg_accum;
    logic [31:0]        n_seg_goal;

    // result register
    logic               r_out_valid;
    logic signed [9:0]  r_right;
    logic signed [9:0]  r_left;
    logic               r_busy;
    logic               r_done;
    logic [2:0]         r_step;

    logic signed [9:0]  n_right;
    logic signed [9:0]  n_left;
    logic               n_done;

    logic               in_acc;

    logic signed [31:0] macc;
    logic signed [31:0] sacc;
    logic [2:0]         cur_seg_kind;
    logic [5:1]         seg_live;
    logic [2:0]         enter_start;
    logic               found;
    logic [2:0]         next_seg;
    logic [15:0]        mul_a;
    logic [15:0]        mul_b;
    logic [31:0]        product;
    logic signed [31:0] check_accum;
    logic               do_enter;
    logic [2:0]         out_kind;
    logic [8:0]         out_speed;
    logic signed [9:0]  spd_pos;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_running    = r_running;
        n_side       = r_side;
        n_speed      = r_speed;
        n_main_accum = r_main_accum;
        n_main_goal  = r_main_goal;
        n_seg_accum  = r_seg_accum;
        n_seg_goal   = r_seg_goal;
        n_done       = 1'b0;
        do_enter     = 1'b0;

        macc         = sat_add(r_main_accum, is_turn(r_kind) ? i_angle_delta
                                                             : i_distance_delta);
        cur_seg_kind = seg_kind(r_phase, r_side);
        sacc         = sat_add(r_seg_accum, is_turn(cur_seg_kind) ? i_angle_delta
                                                                  : i_distance_delta);

        // a segment with a zero goal is met on entry, skip it
        seg_live[1] = (cfg.backup_length != '0) && (cfg.linear_scale != '0);
        seg_live[2] = (cfg.detour_angle != '0) && (cfg.turn_scale != '0);
        seg_live[3] = (cfg.sidestep_length != '0) && (cfg.linear_scale != '0);
        seg_live[4] = seg_live[2];
        seg_live[5] = (cfg.pass_length != '0) && (cfg.linear_scale != '0);

        enter_start = (r_phase == PH_MAIN) ? 3'd1 : 3'(r_phase + 3'd1);
        found       = 1'b0;
        next_seg    = 3'd0;
        for (int p = 5; p >= 1; p--) begin
            if ((3'(p) >= enter_start) && seg_live[3'(p)]) begin
                found    = 1'b1;
                next_seg = 3'(p);
            end
        end

        // one multiplier: start goal or next segment goal
        if (i_req_type == REQ_START) begin
            mul_a = i_target_amount;
            mul_b = is_turn(i_move_kind) ? cfg.turn_scale : cfg.linear_scale;
        end else begin
            case (t_phase'(next_seg))
                PH_BACKUP: begin
                    mul_a = cfg.backup_length;
                    mul_b = cfg.linear_scale;
                end
                PH_TURN_OUT, PH_TURN_BACK: begin
                    mul_a = {7'd0, cfg.detour_angle};
                    mul_b = cfg.turn_scale;
                end
                PH_SIDESTEP: begin
                    mul_a = cfg.sidestep_length;
                    mul_b = cfg.linear_scale;
                end
                default: begin
                    mul_a = cfg.pass_length;
                    mul_b = cfg.linear_scale;
                end
            endcase
        end
        product = mul_a * mul_b;

        check_accum = (r_phase == PH_MAIN) ? macc : r_main_accum;

        if (i_req_type == REQ_START) begin
            if (i_move_kind <= KIND_CW) begin
                n_kind       = i_move_kind;
                n_speed      = sat_speed(i_drive_speed);
                n_main_accum = '0;
                n_main_goal  = product;
                n_seg_accum  = '0;
                n_seg_goal   = '0;
                n_phase      = PH_MAIN;
                n_running    = 1'b1;
                if ((mul_a == '0) || (mul_b == '0)) begin
                    n_running = 1'b0;
                    n_done    = 1'b1;
                end
            end
        end else if (r_running) begin
            if (r_phase == PH_MAIN) begin
                n_main_accum = macc;
                if ((r_kind == KIND_AVOID) && (i_bump_left || i_bump_right)) begin
                    n_side   = i_bump_left;
                    do_enter = 1'b1;
                end else if (reached(r_kind, macc, r_main_goal)) begin
                    n_running = 1'b0;
                    n_phase   = PH_MAIN;
                    n_done    = 1'b1;
                end
            end else begin
                n_seg_accum = sacc;
                if (reached(cur_seg_kind, sacc, r_seg_goal)) begin
                    do_enter = 1'b1;
                end
            end
        end

        if (do_enter) begin
            if (found) begin
                n_seg_goal  = product;
                n_seg_accum = '0;
                n_phase     = t_phase'(next_seg);
            end else begin
                // detour used up, resume the main move and check it again
                n_phase = PH_MAIN;
                if (reached(r_kind, check_accum, r_main_goal)) begin
                    n_running = 1'b0;
                    n_done    = 1'b1;
                end
            end
        end

        out_kind  = (n_phase == PH_MAIN) ? n_kind : seg_kind(n_phase, n_side);
        out_speed = (n_phase == PH_MAIN) ? n_speed
                  : sat_speed(is_turn(out_kind) ? cfg.detour_turn_speed
                                                : cfg.detour_drive_speed);
        spd_pos   = $signed({1'b0, out_speed});
        if (!n_running) begin
            n_right = '0;
            n_left  = '0;
        end else begin
            case (out_kind)
                KIND_BACK: begin
                    n_right = -spd_pos;
                    n_left  = -spd_pos;
                end
                KIND_CCW: begin
                    n_right = spd_pos;
                    n_left  = -spd_pos;
                end
                KIND_CW: begin
                    n_right = -spd_pos;
                    n_left  = spd_pos;
                end
                default: begin
                    n_right = spd_pos;
                    n_left  = spd_pos;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAIN;
            r_kind       <= KIND_AVOID;
            r_running    <= 1'b0;
            r_side       <= 1'b0;
            r_speed      <= '0;
            r_main_accum <= '0;
            r_main_goal  <= '0;
            r_seg_accum  <= '0;
            r_seg_goal   <= '0;
        end else if (in_acc) begin
            r_phase      <= n_phase;
            r_kind       <= n_kind;
            r_running    <= n_running;
            r_side       <= n_side;
            r_speed      <= n_speed;
            r_main_accum <= n_main_accum;
            r_main_goal  <= n_main_goal;
            r_seg_accum  <= n_seg_accum;
            r_seg_goal   <= n_seg_goal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_right <= n_right;
            r_left  <= n_left;
            r_busy  <= n_running;
            r_done  <= n_done;
            r_step  <= n_running ? 3'(n_phase) : 3'd0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_right_wheel = r_right;
    assign o_left_wheel  = r_left;
    assign o_busy_res    = r_busy;
    assign o_done_res    = r_done;
    assign o_detour_step = r_step;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> !r_busy)
        else $error("finished move still reported busy");

    a_idle_wheels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_busy) |-> ((r_right == '0) && (r_left == '0) && (r_step == '0)))
        else $error("idle result carries wheel speed or detour step");

    a_idle_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_phase == PH_MAIN))
        else $error("detour phase held while no move runs");

    a_detour_avoid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_MAIN) |-> (r_kind == KIND_AVOID))
        else $error("detour in a move that does not avoid");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!in_acc && $past(i_rst_n)) |=> ($stable(r_main_accum) && $stable(r_phase)))
        else $error("move state changed without an accepted item");

endmodule
